// File: hdl/caps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package caps_pkg;
	localparam int unsigned MaxLevelsDefault = 1024;
	localparam int unsigned SumW = 43;

	typedef struct packed {
		logic        level_present;
		logic [31:0] level_price;
		logic [31:0] level_bid;
		logic [31:0] level_ask;
		logic [31:0] market_bid;
		logic [31:0] market_ask;
		logic        ref_valid;
		logic [31:0] ref_price;
		logic        last_item;
	} caps_in_t;

	typedef struct packed {
		logic        found;
		logic [31:0] chosen_price;
		logic [47:0] match_volume;
		logic        ref_echo_valid;
		logic [31:0] ref_echo;
		logic        overflow;
	} caps_out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // item transfer
		logic clr_pass;  // restart scan index
		logic step;      // advance scan, read next entry
		logic [1:0] pass; // 0 min pass, 1 survivor pass, 2 reference pass
		logic emit;
		logic finish;    // clear book state
	} caps_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_entry;  // entry in evaluation is the final one
		logic overflow;
		logic empty;
		logic any_band;
		logic need_ref;
	} caps_sts_t;

	localparam logic [1:0] PassMin = 2'd0;
	localparam logic [1:0] PassSel = 2'd1;
	localparam logic [1:0] PassRef = 2'd2;

	function automatic logic [SumW:0] absdiff(input logic [SumW:0] a, input logic [SumW:0] b);
		absdiff = (a > b) ? a - b : b - a;
	endfunction
endpackage
`default_nettype wire

// File: hdl/caps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module caps_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic last_in,
	input  wire caps_pkg::caps_sts_t sts,
	output logic busy,
	output caps_pkg::caps_cmd_t cmd
);
	import caps_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PRE0  = 7'b0000010,
		S_MIN   = 7'b0000100,
		S_PRE1  = 7'b0001000,
		S_SEL   = 7'b0010000,
		S_REF   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] pass_q, pass_d;

	always_comb begin
		state_d = state_q;
		pass_d = pass_q;
		cmd = '0;
		cmd.pass = pass_q;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_in) begin
						state_d = S_PRE0;
					end
				end
			end
			S_PRE0: begin
				if (sts.overflow || sts.empty) begin
					state_d = S_OUT;
				end else begin
					cmd.clr_pass = 1'b1;
					pass_d = PassMin;
					state_d = S_MIN;
				end
			end
			S_MIN, S_SEL, S_REF: begin
				cmd.step = 1'b1;
				if (sts.last_entry) begin
					state_d = S_PRE1;
				end
			end
			S_PRE1: begin
				// only a new pass restarts the scan; selection state must survive otherwise
				if (pass_q == PassMin && sts.any_band) begin
					cmd.clr_pass = 1'b1;
					pass_d = PassSel;
					state_d = S_SEL;
				end else if (pass_q == PassSel && sts.need_ref) begin
					cmd.clr_pass = 1'b1;
					pass_d = PassRef;
					state_d = S_REF;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.emit = 1'b1;
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		cmd.pass = pass_d;
		if (state_q == S_MIN || state_q == S_SEL || state_q == S_REF) begin
			cmd.pass = pass_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q <= PassMin;
		end else begin
			state_q <= state_d;
			pass_q <= pass_d;
		end
	end

	a_out_from_pre: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> $past(state_q) == S_PRE0 || $past(state_q) == S_PRE1)
		else $error("result state entered out of order");
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && start && last_in |=> busy)
		else $error("not busy after last item");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE)
		else $error("no return to idle after result");
endmodule
`default_nettype wire

// File: hdl/caps_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module caps_dp #(
	parameter int unsigned MAX_LEVELS = caps_pkg::MaxLevelsDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire caps_pkg::caps_in_t in_item,
	input  wire caps_pkg::caps_cmd_t cmd,
	output caps_pkg::caps_sts_t sts,
	output logic strobe,
	output caps_pkg::caps_out_t res
);
	import caps_pkg::*;

	localparam int unsigned AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int unsigned CW = $clog2(MAX_LEVELS + 1);
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_LEVELS);

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] bid;
		logic [31:0] ask;
		logic [SumW-1:0] ask_pre;
		logic [SumW-1:0] bid_below;
	} entry_t;

	entry_t mem [MAX_LEVELS];
	entry_t rd_s1;

	logic [CW-1:0] count_q;
	logic [SumW-1:0] ask_sum_q, bid_sum_q;
	logic ovf_q;
	logic [31:0] mb_q, ma_q, rp_q;
	logic rv_q;

	logic [AW-1:0] rd_addr_q;   // next address to read
	logic [CW-1:0] eval_idx_q;  // index of entry in rd_s1
	logic eval_v_q;

	// selection state
	logic have_min_q, any_q;
	logic [SumW:0] min_q;
	logic [31:0] lo_price_q, hi_price_q, ch_price_q;
	logic [SumW:0] ch_vol_q, lo_vol_q, hi_vol_q;
	logic [CW-1:0] cnt_q;
	logic sell_q, buy_q;
	logic [32:0] best_q;

	// per-entry evaluation
	logic [SumW:0] ca, cb, diff, vol;
	logic band;
	always_comb begin
		ca = {1'b0, rd_s1.ask_pre} + (SumW+1)'(ma_q);
		cb = (SumW+1)'(bid_sum_q - rd_s1.bid_below) + (SumW+1)'(mb_q);
		band = (ca != '0) && (cb != '0)
			&& ((SumW+1)'(ca + (SumW+1)'(rd_s1.bid)) >= cb)
			&& ((SumW+1)'(cb + (SumW+1)'(rd_s1.ask)) >= ca);
		diff = absdiff(ca, cb);
		vol = (cb < ca) ? cb : ca;
	end

	logic [32:0] rdist;
	assign rdist = (rd_s1.price > rp_q) ? {1'b0, rd_s1.price - rp_q}
		: {1'b0, rp_q - rd_s1.price};

	always_ff @(posedge clk) begin
		if (cmd.load && in_item.level_present && count_q < MaxCnt) begin
			mem[count_q[AW-1:0]] <= '{price: in_item.level_price, bid: in_item.level_bid,
				ask: in_item.level_ask, ask_pre: ask_sum_q + SumW'(in_item.level_ask),
				bid_below: bid_sum_q};
		end
		// entry 0 is read in the cycle a pass is restarted
		rd_s1 <= mem[cmd.clr_pass ? AW'(0) : rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ask_sum_q <= '0;
			bid_sum_q <= '0;
			ovf_q <= 1'b0;
			rd_addr_q <= '0;
			eval_v_q <= 1'b0;
			eval_idx_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit;
			if (cmd.load) begin
				if (in_item.level_present) begin
					if (count_q < MaxCnt) begin
						count_q <= count_q + 1'b1;
						ask_sum_q <= ask_sum_q + SumW'(in_item.level_ask);
						bid_sum_q <= bid_sum_q + SumW'(in_item.level_bid);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (cmd.clr_pass) begin
				rd_addr_q <= AW'(1);
				eval_idx_q <= '0;
				eval_v_q <= 1'b0;
			end else if (cmd.step) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				eval_idx_q <= eval_idx_q + 1'b1;
			end
			if (cmd.finish) begin
				count_q <= '0;
				ask_sum_q <= '0;
				bid_sum_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && in_item.last_item) begin
			mb_q <= in_item.market_bid;
			ma_q <= in_item.market_ask;
			rv_q <= in_item.ref_valid;
			rp_q <= in_item.ref_valid ? in_item.ref_price : 32'd0;
		end
		if (cmd.clr_pass) begin
			if (cmd.pass == PassMin) begin
				have_min_q <= 1'b0;
				any_q <= 1'b0;
			end else if (cmd.pass == PassSel) begin
				cnt_q <= '0;
				sell_q <= 1'b1;
				buy_q <= 1'b1;
			end else begin
				ch_price_q <= lo_price_q;
				ch_vol_q <= lo_vol_q;
				best_q <= (lo_price_q > rp_q) ? {1'b0, lo_price_q - rp_q}
					: {1'b0, rp_q - lo_price_q};
			end
		end else if (cmd.step) begin
			if (cmd.pass == PassMin) begin
				if (band) begin
					if (!have_min_q || diff < min_q) min_q <= diff;
					have_min_q <= 1'b1;
					any_q <= 1'b1;
				end
			end else if (band && diff == min_q) begin
				if (cmd.pass == PassSel) begin
					if (cnt_q == '0) begin
						lo_price_q <= rd_s1.price;
						lo_vol_q <= vol;
					end
					hi_price_q <= rd_s1.price;
					hi_vol_q <= vol;
					if (cnt_q < CW'(2)) cnt_q <= cnt_q + 1'b1;
					if (ca <= cb) sell_q <= 1'b0;
					if (ca >= cb) buy_q <= 1'b0;
				end else if (rdist <= best_q) begin
					best_q <= rdist;
					ch_price_q <= rd_s1.price;
					ch_vol_q <= vol;
				end
			end
		end
	end

	// side and reference tie-breaks that need no nearest-price pass
	logic use_hi;
	always_comb begin
		use_hi = 1'b0;
		if (cnt_q > CW'(1)) begin
			if (min_q != '0 && sell_q) use_hi = 1'b0;
			else if (min_q != '0 && buy_q) use_hi = 1'b1;
			else if ({1'b0, rp_q} > {1'b0, hi_price_q}) use_hi = 1'b1;
		end
	end

	logic need_ref;
	assign need_ref = (cnt_q > CW'(1)) && !(min_q != '0 && (sell_q || buy_q))
		&& !(rp_q > hi_price_q) && !(rp_q < lo_price_q);

	logic ref_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ref_done_q <= 1'b0;
		else if (cmd.clr_pass) ref_done_q <= (cmd.pass == PassRef);
		else if (cmd.finish) ref_done_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res.ref_echo_valid <= rv_q;
			res.ref_echo <= rp_q;
			res.overflow <= ovf_q;
			if (ovf_q || count_q == '0 || !any_q) begin
				res.found <= 1'b0;
				res.chosen_price <= '0;
				res.match_volume <= '0;
			end else begin
				res.found <= 1'b1;
				if (ref_done_q) begin
					res.chosen_price <= ch_price_q;
					res.match_volume <= 48'(ch_vol_q);
				end else if (use_hi) begin
					res.chosen_price <= hi_price_q;
					res.match_volume <= 48'(hi_vol_q);
				end else begin
					res.chosen_price <= lo_price_q;
					res.match_volume <= 48'(lo_vol_q);
				end
			end
		end
	end

	assign sts.last_entry = (eval_idx_q + 1'b1) == count_q;
	assign sts.overflow = ovf_q;
	assign sts.empty = (count_q == '0);
	assign sts.any_band = any_q;
	assign sts.need_ref = need_ref;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxCnt) else $error("level count beyond capacity");
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> count_q == '0 && !ovf_q) else $error("book state not cleared");
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> eval_idx_q < count_q) else $error("scan beyond stored levels");
endmodule
`default_nettype wire

// File: hdl/call_auction_price_select_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Call auction price selector.
// Levels of one book enter through start/busy, one level per transfer, in
// ascending price order; the transfer with last_item set closes the book and
// carries the market volumes and the reference price.
// A non-last item is taken in the cycle it is offered (busy stays low).
// After the last item the block is busy for its passes over the N stored levels:
// a minimum-imbalance pass, a survivor pass when some level is in the band, and,
// only when the reference price decides, a nearest-price pass over the level
// memory, which has one read port and reads one entry per cycle.
// A result appears only after a last item: one cycle with done high and the
// fields on result. An empty book or an empty band gives no strobe; an
// overflowed book gives one with found = 0 and overflow = 1.
// The receiver cannot stall; a result is valid for that single cycle only.
// Reset clears count, sums and the controller; the level memory needs no
// clearing since only entries of the current book are read.
module call_auction_price_select_core #(
	parameter int unsigned MAX_LEVELS = caps_pkg::MaxLevelsDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire caps_pkg::caps_in_t item,
	output logic done,
	output caps_pkg::caps_out_t result
);
	import caps_pkg::*;

	caps_cmd_t cmd;
	caps_sts_t sts;
	logic strobe;

	caps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_in(item.last_item),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	caps_dp #(.MAX_LEVELS(MAX_LEVELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(item), .cmd(cmd), .sts(sts),
		.strobe(strobe), .res(result)
	);

	// suppress strobe for no-result books
	assign done = strobe && (result.found || result.overflow);
endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import caps_pkg::*;

	localparam int DEPTH = 1024;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	caps_in_t item = '0;
	logic done;
	caps_out_t result;

	call_auction_price_select_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always #2 clk = ~clk;

	// book model
	logic [31:0] lvl_price [DEPTH];
	logic [31:0] lvl_bid [DEPTH];
	logic [31:0] lvl_ask [DEPTH];
	longint unsigned ask_upto [DEPTH];
	longint unsigned bid_below [DEPTH];
	int unsigned n_levels = 0;
	longint unsigned ask_total = 0, bid_total = 0;
	bit book_overflow = 0;

	caps_in_t pending_items[$];
	caps_out_t expected_prices[$];
	int errors = 0;
	int n_items = 0;

	function automatic longint unsigned adiff(longint unsigned a, longint unsigned b);
		return a > b ? a - b : b - a;
	endfunction

	function automatic longint unsigned cum_ask(int i, longint unsigned ma);
		return ma + ask_upto[i];
	endfunction

	function automatic longint unsigned cum_bid(int i, longint unsigned mb);
		return mb + (bid_total - bid_below[i]);
	endfunction

	function automatic bit crosses(int i, longint unsigned mb, longint unsigned ma);
		longint unsigned cb, ca;
		cb = cum_bid(i, mb);
		ca = cum_ask(i, ma);
		if (cb == 0 || ca == 0) return 0;
		return (ca + lvl_bid[i] >= cb) && (cb + lvl_ask[i] >= ca);
	endfunction

	// Adds the item's level to the book model; for a last item, selects the equilibrium price of the book.
	task automatic price_book(input caps_in_t it);
		longint unsigned mb, ma, rp, min_imb, cb, ca, d, best_d;
		bit any, all_sell, all_buy;
		int lo, hi, cnt, pick;
		caps_out_t r;
		if (it.level_present) begin
			if (n_levels < DEPTH) begin
				lvl_price[n_levels] = it.level_price;
				lvl_bid[n_levels] = it.level_bid;
				lvl_ask[n_levels] = it.level_ask;
				bid_below[n_levels] = bid_total;
				bid_total += it.level_bid;
				ask_total += it.level_ask;
				ask_upto[n_levels] = ask_total;
				n_levels++;
			end else
				book_overflow = 1;
		end
		if (!it.last_item) return;
		mb = it.market_bid;
		ma = it.market_ask;
		rp = it.ref_valid ? it.ref_price : 0;
		r = '0;
		r.ref_echo_valid = it.ref_valid;
		r.ref_echo = rp;
		any = 0; min_imb = 0; all_sell = 1; all_buy = 1;
		lo = 0; hi = 0; cnt = 0;
		if (book_overflow) begin
			r.overflow = 1;
			expected_prices = {expected_prices, r};
		end else if (n_levels > 0) begin
			for (int i = 0; i < n_levels; i++)
				if (crosses(i, mb, ma)) begin
					d = adiff(cum_bid(i, mb), cum_ask(i, ma));
					if (!any || d < min_imb) min_imb = d;
					any = 1;
				end
			if (any) begin
				for (int i = 0; i < n_levels; i++) begin
					if (!crosses(i, mb, ma)) continue;
					cb = cum_bid(i, mb);
					ca = cum_ask(i, ma);
					if (adiff(cb, ca) != min_imb) continue;
					if (cnt == 0) lo = i;
					hi = i;
					cnt++;
					if (ca <= cb) all_sell = 0;
					if (ca >= cb) all_buy = 0;
				end
				pick = lo;
				if (cnt > 1) begin
					if (min_imb > 0 && all_sell) pick = lo;
					else if (min_imb > 0 && all_buy) pick = hi;
					else if (rp > lvl_price[hi]) pick = hi;
					else if (rp < lvl_price[lo]) pick = lo;
					else begin
						best_d = adiff(lvl_price[lo], rp);
						for (int i = 0; i < n_levels; i++) begin
							if (!crosses(i, mb, ma)) continue;
							if (adiff(cum_bid(i, mb), cum_ask(i, ma)) != min_imb) continue;
							d = adiff(lvl_price[i], rp);
							if (d <= best_d) begin
								best_d = d;
								pick = i;
							end
						end
					end
				end
				cb = cum_bid(pick, mb);
				ca = cum_ask(pick, ma);
				r.found = 1;
				r.chosen_price = lvl_price[pick];
				r.match_volume = cb < ca ? cb : ca;
				expected_prices = {expected_prices, r};
			end
		end
		n_levels = 0;
		ask_total = 0;
		bid_total = 0;
		book_overflow = 0;
	endtask

	// driver: bursts with gaps
	int burst_left = 4, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
		end else begin
			if (start && !busy) begin
				price_book(item);
				n_items++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 0;
				end else if (pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					start <= 1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else
					start <= 0;
			end
		end
	end

	// monitor
	caps_out_t want;
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_prices.size() == 0) begin
				$error("unexpected result %p", result);
				errors++;
			end else begin
				want = expected_prices.pop_front();
				if (result.found !== want.found) begin
					$error("found: expected %0d actual %0d", want.found, result.found); errors++;
				end
				if (result.chosen_price !== want.chosen_price) begin
					$error("chosen_price: expected %0d actual %0d",
						want.chosen_price, result.chosen_price); errors++;
				end
				if (result.match_volume !== want.match_volume) begin
					$error("match_volume: expected %0d actual %0d",
						want.match_volume, result.match_volume); errors++;
				end
				if (result.ref_echo_valid !== want.ref_echo_valid) begin
					$error("ref_echo_valid: expected %0d actual %0d",
						want.ref_echo_valid, result.ref_echo_valid); errors++;
				end
				if (result.ref_echo !== want.ref_echo) begin
					$error("ref_echo: expected %0d actual %0d", want.ref_echo, result.ref_echo);
					errors++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0d actual %0d", want.overflow, result.overflow);
					errors++;
				end
			end
		end
	end

	// volume flavors: 0 tiny (forces ties), 1 full range, 2 extremes
	function automatic logic [31:0] pick_vol(int flavor);
		case (flavor)
			0: return $urandom_range(0, 3);
			1: return $urandom;
			default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	int queued = 0;

	task automatic add_book(int n, int flavor, bit scramble, bit last_has_level);
		caps_in_t it;
		logic [31:0] px;
		logic [31:0] base;
		base = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF - 32'(n * 4 + 8) : $urandom_range(0, 5000);
		px = base;
		for (int k = 0; k < n + (last_has_level ? 0 : 1); k++) begin
			it = '0;
			it.level_price = $urandom;
			it.level_bid = $urandom;
			it.level_ask = $urandom;
			it.market_bid = $urandom;
			it.market_ask = $urandom;
			it.ref_price = $urandom;
			it.ref_valid = $urandom_range(0, 1);
			it.last_item = (k == n + (last_has_level ? 0 : 1) - 1);
			it.level_present = (k < n);
			if (k < n) begin
				px = px + $urandom_range(1, 4);
				it.level_price = scramble ? $urandom : px;
				it.level_bid = pick_vol(flavor);
				it.level_ask = pick_vol(flavor);
			end
			if (it.last_item) begin
				it.market_bid = $urandom_range(0, 2) == 0 ? 0 : pick_vol(flavor);
				it.market_ask = $urandom_range(0, 2) == 0 ? 0 : pick_vol(flavor);
				if ($urandom_range(0, 2) != 0) it.ref_price = base + $urandom_range(0, n * 4 + 8);
			end
			// stray empty items inside the book are ignored by the block
			if (!it.last_item && $urandom_range(0, 15) == 0) begin
				caps_in_t stray;
				stray = it;
				stray.level_present = 0;
				pending_items = {pending_items, stray};
			end
			pending_items = {pending_items, it};
			queued++;
		end
	endtask

	initial begin
		int ovf_at;
		caps_in_t it;
		// directed
		it = '0; it.last_item = 1;
		pending_items = {pending_items, it};            // empty book
		it.market_bid = 32'hFFFF_FFFF; it.market_ask = 32'hFFFF_FFFF;
		it.ref_valid = 1; it.ref_price = 32'hFFFF_FFFF;
		pending_items = {pending_items, it};            // market volume only
		it = '1; pending_items = {pending_items, it};   // one level, all ones
		it = '0; it.level_present = 1; it.level_bid = 5; it.level_ask = 0;
		it.level_price = 10; it.last_item = 1;
		pending_items = {pending_items, it};            // one-sided, empty band
		add_book(3, 0, 0, 1);
		add_book(4, 0, 0, 0);
		add_book(3, 2, 0, 1);
		add_book(5, 0, 1, 1);
		queued = 0;
		ovf_at = $urandom_range(100, 600);
		while (queued < 1700) begin
			if (queued >= ovf_at && ovf_at > 0) begin
				add_book(DEPTH + 2, 1, 0, 1);
				ovf_at = 0;
			end else if ($urandom_range(0, 19) == 0)
				add_book(0, 1, 0, 0);
			else
				add_book($urandom_range(0, 9) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8),
					$urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 2),
					$urandom_range(0, 9) == 0, $urandom_range(0, 1));
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;
		wait (pending_items.size() == 0);
		@(posedge clk);
		while (start || expected_prices.size() != 0) @(posedge clk);
		repeat (3 * DEPTH + 20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#4ms;
		$display("Verification failed");
		$finish;
	end
endmodule
